FILE: hdl/indexed_array_insert_delete_defines.svh
// assertion macros for the indexed list block
`ifndef INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IAID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list check failed");
// next-cycle implication
`define IAID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list check failed");
`else
`define IAID_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IAID_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/iaid_pkg.sv
// types and constants of the indexed list block
`timescale 1ns / 1ps
package iaid_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_DUMP     = 16;

  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_TUSER_W  = 2;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DMP_RD,
    S_DMP_WR,
    S_RESP
  } state_t;

endpackage

FILE: hdl/indexed_array_insert_delete.sv
// top level of the indexed list block: sequencer, entry memory and result register
`timescale 1ns / 1ps
`include "indexed_array_insert_delete_defines.svh"
// Indexed list with insert, delete and dump.
// in_* channel: one command per transfer, in_tdata holds func, index and value.
// out_* channel: results; out_tuser holds the status, out_tlast marks the final
// result of a command. Insert and delete give one result each; dump gives one
// result per stored entry (at most 16), or one empty-status result.
// Flow: one command at a time, in_tready is high only while the sequencer is
// idle. A rejected command or unused code goes straight to its result. Insert
// moves the entries at and above the index up one place, top first, and then
// writes the new value; delete moves each entry above the index down one place.
// Each move reads the entry and then writes it back, through the one read and
// one write port of the entry memory. Dump reads each entry, then loads it out.
// Reset clears the length and the sequencer; entries need no clearing since
// only entries below the length are ever read, so there is no sweep.
// A stalled receiver holds the result register; the sequencer waits for the
// slot to free up, and a finished result does not block the next command.
module indexed_array_insert_delete #(
  parameter int CAPACITY = iaid_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] func, [6:2] index, [38:7] value, [39] zero
  input  logic [iaid_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] position, [35:4] element, [40:36] count, [47:41] zero
  output logic [iaid_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [iaid_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                               out_tlast
);
  import iaid_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = (LW > 5) ? LW : 5;
  localparam logic [LW-1:0] LEN_MAX = LW'(CAPACITY);

  // input fields
  logic [1:0]  in_func;
  logic [4:0]  in_index;
  logic [31:0] in_value;
  assign in_func  = in_tdata[1:0];
  assign in_index = in_tdata[6:2];
  assign in_value = in_tdata[38:7];

  state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [LW-1:0] idx_r;
  logic [31:0]   val_r;
  logic [1:0]    status_r;

  // entry memory, one read and one write port
  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_pos_r;
  logic [31:0]   out_elem_r;
  logic [4:0]    out_cnt_r;
  logic [1:0]    out_status_r;
  logic          out_last_r;
  logic          out_load;
  logic [3:0]    load_pos;
  logic [31:0]   load_elem;
  logic [1:0]    load_status;
  logic          load_last;

  logic          in_fire;
  logic          slot_free;
  logic [CW-1:0] idx_ext, len_ext, ptr_ext, cap_ext, dump_n;
  logic [LW-1:0] ptr_dec, ptr_inc;
  logic          dump_last;
  logic          del_done;

  // command decode
  logic [1:0]    dec_status;
  state_t        dec_state;

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign idx_ext   = CW'(in_index);
  assign len_ext   = CW'(len_r);
  assign ptr_ext   = CW'(ptr_r);
  assign cap_ext   = CW'(CAPACITY);
  assign dump_n    = (len_ext > CW'(MAX_DUMP)) ? CW'(MAX_DUMP) : len_ext;
  assign ptr_dec   = ptr_r - 1'b1;
  assign ptr_inc   = ptr_r + 1'b1;
  assign dump_last = (ptr_ext + 1'b1) == dump_n;
  assign del_done  = (ptr_ext + 1'b1) >= len_ext;

  // checks an accepted command against the current length
  always_comb begin
    dec_status = STATUS_OK;
    dec_state  = S_RESP;
    unique case (in_func)
      FUNC_INSERT: begin
        if (len_ext >= cap_ext) begin
          dec_status = STATUS_FULL;
        end else if (idx_ext > len_ext) begin
          dec_status = STATUS_RANGE;
        end else begin
          dec_state = S_INS_RD;
        end
      end
      FUNC_DELETE: begin
        if (len_r == '0) begin
          dec_status = STATUS_EMPTY;
        end else if (idx_ext >= len_ext) begin
          dec_status = STATUS_RANGE;
        end else begin
          dec_state = S_DEL_RD;
        end
      end
      FUNC_DUMP: begin
        if (len_r == '0) begin
          dec_status = STATUS_EMPTY;
        end else begin
          dec_state = S_DMP_RD;
        end
      end
      default: begin
        dec_status = STATUS_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = dec_state;
      S_INS_RD: state_nxt = (ptr_r == idx_r) ? S_RESP : S_INS_WR;
      S_INS_WR: state_nxt = S_INS_RD;
      S_DEL_RD: state_nxt = del_done ? S_RESP : S_DEL_WR;
      S_DEL_WR: state_nxt = S_DEL_RD;
      S_DMP_RD: state_nxt = S_DMP_WR;
      S_DMP_WR: begin
        if (slot_free) state_nxt = dump_last ? S_IDLE : S_DMP_RD;
      end
      S_RESP:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ptr_r[AW-1:0];
    mem_wdata   = rd_data_r;
    rd_en       = 1'b0;
    rd_addr     = ptr_r[AW-1:0];
    ptr_nxt     = ptr_r;
    len_nxt     = len_r;
    out_load    = 1'b0;
    load_pos    = '0;
    load_elem   = '0;
    load_status = status_r;
    load_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          unique case (in_func)
            FUNC_INSERT: ptr_nxt = len_r;
            FUNC_DELETE: ptr_nxt = LW'(in_index);
            default:     ptr_nxt = '0;
          endcase
        end
      end
      S_INS_RD: begin
        if (ptr_r == idx_r) begin
          // slot is open, drop the new word in
          mem_we    = 1'b1;
          mem_wdata = val_r;
          len_nxt   = len_r + 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec[AW-1:0];
        end
      end
      S_INS_WR: begin
        // move entry up one place
        mem_we  = 1'b1;
        ptr_nxt = ptr_dec;
      end
      S_DEL_RD: begin
        if (del_done) begin
          len_nxt = len_r - 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc[AW-1:0];
        end
      end
      S_DEL_WR: begin
        // move entry down one place
        mem_we  = 1'b1;
        ptr_nxt = ptr_inc;
      end
      S_DMP_RD: begin
        rd_en = 1'b1;
      end
      S_DMP_WR: begin
        if (slot_free) begin
          out_load    = 1'b1;
          load_pos    = ptr_ext[3:0];
          load_elem   = rd_data_r;
          load_status = STATUS_OK;
          load_last   = dump_last;
          ptr_nxt     = ptr_inc;
        end
      end
      S_RESP: begin
        out_load = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (in_fire) begin
      idx_r    <= LW'(in_index);
      val_r    <= in_value;
      status_r <= dec_status;
    end
    if (out_load) begin
      out_pos_r    <= load_pos;
      out_elem_r   <= load_elem;
      out_cnt_r    <= len_ext[4:0];
      out_status_r <= load_status;
      out_last_r   <= load_last;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_elem_r, out_pos_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // length never passes the capacity
  `IAID_ASSERT_IMP(a_len_cap, clk, rst_n, 1'b1, len_r <= LEN_MAX)
  // dump only reads stored entries
  `IAID_ASSERT_IMP(a_dump_range, clk, rst_n, state_r == S_DMP_WR, ptr_r < len_r)
  // insert shift pointer stays between the index and the top
  `IAID_ASSERT_IMP(a_ins_ptr, clk, rst_n, state_r == S_INS_RD, (ptr_r >= idx_r) && (ptr_r < LEN_MAX))
  // length does not move on the transfer of a command
  `IAID_ASSERT_NXT(a_len_hold, clk, rst_n, in_tvalid && in_tready, len_r == $past(len_r))

endmodule
